/* hw/rtl/delta_list_timer_queue_macros.svh */
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication.
`define DLTQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dltq check failed");

// Next-cycle implication.
`define DLTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dltq check failed");

`endif

/* hw/rtl/dltq_pkg.sv */
package dltq_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int ID_BITS_DEF = 8;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 8;
    localparam int AMT_W    = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // datapath actions
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_NONE        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD        = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_SEARCH  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INS_SHIFT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ADV         = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REM_SEARCH  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_REM_COMPACT = 3'd6;

    typedef struct packed {
        logic [ACT_W-1:0]    act;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } dltq_cmd_t;

    typedef struct packed {
        logic at_end;    // walk index has reached the entry count
        logic ins_ge;    // remaining delay >= entry delta
        logic adv_fit;   // entry delta >= remaining ticks
        logic id_match;
        logic full;
    } dltq_stat_t;

endpackage

/* hw/rtl/dltq_if.sv */
interface dltq_req_if
    import dltq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   proc_id;
    logic [AMT_W-1:0]  amount;

    modport source (output valid, mode, proc_id, amount, input ready);
    modport sink   (input valid, mode, proc_id, amount, output ready);
endinterface

interface dltq_rsp_if
    import dltq_pkg::*;
#(
    parameter int CNT_W = $clog2(DEPTH_DEF + 1)
) ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                ready_res;
    logic [ID_W-1:0]     head_id;
    logic [CNT_W-1:0]    entry_count;

    modport source (output valid, status, ready_res, head_id, entry_count, input ready);
    modport sink   (input valid, status, ready_res, head_id, entry_count, output ready);
endinterface

/* hw/rtl/delta_list_timer_queue.sv */
// Walk: a full insert or an unused mode skips the walk; other operations walk up to the
//   occupied entries (one entry walked per cycle) before the response beat.
// One operation at a time: a new request is taken only once the previous response is loaded;
//   the walk pace is set by the single read and single write port of the entry memories.
// Reset (rst_n, async, active low): queue empty, controller idle, no response pending.
//   Entry memories are not cleared; only entries below the count are ever used.
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    dltq_req_if.sink  req,
    dltq_rsp_if.source rsp
);

    `include "delta_list_timer_queue_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Controller sequences the walk; datapath owns the entry memories, the walk
    // index, the count and the response payload registers.
    dltq_cmd_t  cmd;
    dltq_stat_t stat;

    dltq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_mode   (req.mode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dltq_dpath #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS),
        .CNT_W   (CNT_W)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_proc_id      (req.proc_id),
        .in_amount       (req.amount),
        .out_status      (rsp.status),
        .out_ready_res   (rsp.ready_res),
        .out_head_id     (rsp.head_id),
        .out_entry_count (rsp.entry_count)
    );

    // Checks

    // one operation in flight: request side closes after a beat
    `DLTQ_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready)

    // reported count never exceeds capacity
    `DLTQ_ASSERT_NOW(a_count_range, rsp.valid, rsp.entry_count <= CNT_W'(DEPTH))

    // a full report only when the queue really is full
    `DLTQ_ASSERT_NOW(a_full_count, rsp.valid && (rsp.status == ST_FULL),
        rsp.entry_count == CNT_W'(DEPTH))

    // a ready head needs a head
    `DLTQ_ASSERT_NOW(a_ready_nonempty, rsp.valid && rsp.ready_res, rsp.entry_count != '0)

endmodule

/* hw/rtl/dltq_ctrl.sv */
module dltq_ctrl
    import dltq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] in_mode,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dltq_stat_t        stat,
    output dltq_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS     = 3'd1;
    localparam logic [2:0] S_SHIFT   = 3'd2;
    localparam logic [2:0] S_ADV     = 3'd3;
    localparam logic [2:0] S_REM     = 3'd4;
    localparam logic [2:0] S_COMPACT = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;
    logic                out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        cmd.act      = ACT_NONE;
        cmd.out_load = out_load;
        cmd.status   = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.act     = ACT_LOAD;
                    status_next = ST_OK;
                    case (in_mode)
                        MODE_INSERT:
                        begin
                            if (stat.full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_INS;
                            end
                        end
                        MODE_ADVANCE: state_next = S_ADV;
                        MODE_REMOVE:  state_next = S_REM;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_INS:
            begin
                cmd.act = ACT_INS_SEARCH;
                if (stat.at_end)
                    state_next = S_DONE;
                else if (!stat.ins_ge)
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.act = ACT_INS_SHIFT;
                if (stat.at_end)
                    state_next = S_DONE;
            end
            S_ADV:
            begin
                cmd.act = ACT_ADV;
                if (stat.at_end || stat.adv_fit)
                    state_next = S_DONE;
            end
            S_REM:
            begin
                cmd.act = ACT_REM_SEARCH;
                if (stat.at_end)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else if (stat.id_match)
                begin
                    state_next = S_COMPACT;
                end
            end
            S_COMPACT:
            begin
                cmd.act = ACT_REM_COMPACT;
                if (stat.at_end)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/dltq_dpath.sv */
module dltq_dpath
    import dltq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF,
    parameter int CNT_W   = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dltq_cmd_t           cmd,
    output dltq_stat_t          stat,
    input  logic [ID_W-1:0]     in_proc_id,
    input  logic [AMT_W-1:0]    in_amount,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_ready_res,
    output logic [ID_W-1:0]     out_head_id,
    output logic [CNT_W-1:0]    out_entry_count
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SID_W  = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    logic [AMT_W-1:0] delta_mem [DEPTH];
    logic [SID_W-1:0] id_mem    [DEPTH];

    logic [AMT_W-1:0]  rd_delta_reg;
    logic [SID_W-1:0]  rd_id_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [AMT_W-1:0]  wr_delta;
    logic [SID_W-1:0]  wr_id;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [AMT_W-1:0] acc_reg, acc_next;
    logic [SID_W-1:0] wid_reg, wid_next;
    logic [AMT_W-1:0] carry_delta_reg, carry_delta_next;
    logic [SID_W-1:0] carry_id_reg, carry_id_next;

    logic [AMT_W-1:0] head_delta_reg;
    logic [SID_W-1:0] head_id_reg;

    logic [STATUS_W-1:0] status_reg;
    logic                ready_res_reg;
    logic [ID_W-1:0]     head_out_reg;
    logic [CNT_W-1:0]    count_reg;

    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;
    logic [AMT_W-1:0] diff_a;    // acc - delta
    logic [AMT_W-1:0] diff_b;    // delta - acc
    logic [AMT_W:0]   sum_w;
    logic [AMT_W-1:0] sum_sat;

    assign idx_inc = idx_reg + 1'b1;
    assign idx_dec = idx_reg - 1'b1;
    assign diff_a  = acc_reg - rd_delta_reg;
    assign diff_b  = rd_delta_reg - acc_reg;
    assign sum_w   = {1'b0, rd_delta_reg} + {1'b0, carry_delta_reg};
    assign sum_sat = sum_w[AMT_W] ? {AMT_W{1'b1}} : sum_w[AMT_W-1:0];

    assign stat.at_end   = (idx_reg == occ_reg);
    assign stat.ins_ge   = (acc_reg >= rd_delta_reg);
    assign stat.adv_fit  = (rd_delta_reg >= acc_reg);
    assign stat.id_match = (rd_id_reg == wid_reg);
    assign stat.full     = (occ_reg == CNT_W'(DEPTH));

    // read one ahead of the entry being processed
    assign rd_addr = (cmd.act == ACT_LOAD) ? '0 : idx_inc[ADDR_W-1:0];

    always_comb
    begin
        wr_en            = 1'b0;
        wr_addr          = idx_reg[ADDR_W-1:0];
        wr_delta         = carry_delta_reg;
        wr_id            = carry_id_reg;
        idx_next         = idx_reg;
        occ_next         = occ_reg;
        acc_next         = acc_reg;
        wid_next         = wid_reg;
        carry_delta_next = carry_delta_reg;
        carry_id_next    = carry_id_reg;
        case (cmd.act)
            ACT_LOAD:
            begin
                idx_next = '0;
                acc_next = in_amount;
                wid_next = in_proc_id[SID_W-1:0];
            end
            ACT_INS_SEARCH:
            begin
                if (stat.at_end)
                begin
                    wr_en    = 1'b1;
                    wr_delta = acc_reg;
                    wr_id    = wid_reg;
                    occ_next = occ_reg + 1'b1;
                end
                else if (stat.ins_ge)
                begin
                    acc_next = diff_a;
                    idx_next = idx_inc;
                end
                else
                begin
                    // new entry lands here; displaced one is carried with its delta reduced
                    wr_en            = 1'b1;
                    wr_delta         = acc_reg;
                    wr_id            = wid_reg;
                    carry_delta_next = diff_b;
                    carry_id_next    = rd_id_reg;
                    idx_next         = idx_inc;
                end
            end
            ACT_INS_SHIFT:
            begin
                wr_en = 1'b1;
                if (stat.at_end)
                begin
                    occ_next = occ_reg + 1'b1;
                end
                else
                begin
                    carry_delta_next = rd_delta_reg;
                    carry_id_next    = rd_id_reg;
                    idx_next         = idx_inc;
                end
            end
            ACT_ADV:
            begin
                if (!stat.at_end)
                begin
                    wr_en = 1'b1;
                    wr_id = rd_id_reg;
                    if (stat.adv_fit)
                    begin
                        wr_delta = diff_b;
                    end
                    else
                    begin
                        wr_delta = '0;
                        acc_next = diff_a;
                        idx_next = idx_inc;
                    end
                end
            end
            ACT_REM_SEARCH:
            begin
                if (!stat.at_end)
                begin
                    if (stat.id_match)
                        carry_delta_next = rd_delta_reg;
                    idx_next = idx_inc;
                end
            end
            ACT_REM_COMPACT:
            begin
                if (stat.at_end)
                begin
                    occ_next = occ_reg - 1'b1;
                end
                else
                begin
                    // pull entry back one place; removed delta merges into first successor
                    wr_en            = 1'b1;
                    wr_addr          = idx_dec[ADDR_W-1:0];
                    wr_delta         = sum_sat;
                    wr_id            = rd_id_reg;
                    carry_delta_next = '0;
                    idx_next         = idx_inc;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            delta_mem[wr_addr] <= wr_delta;
            id_mem[wr_addr]    <= wr_id;
        end
        rd_delta_reg <= delta_mem[rd_addr];
        rd_id_reg    <= id_mem[rd_addr];
    end

    // shadow of entry 0
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == '0))
        begin
            head_delta_reg <= wr_delta;
            head_id_reg    <= wr_id;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        wid_reg         <= wid_next;
        carry_delta_reg <= carry_delta_next;
        carry_id_reg    <= carry_id_next;
        if (cmd.out_load)
        begin
            status_reg    <= cmd.status;
            ready_res_reg <= (occ_reg != '0) && (head_delta_reg == '0);
            head_out_reg  <= (occ_reg != '0) ? ID_W'(head_id_reg) : '0;
            count_reg     <= occ_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            occ_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            occ_reg <= occ_next;
        end
    end

    assign out_status      = status_reg;
    assign out_ready_res   = ready_res_reg;
    assign out_head_id     = head_out_reg;
    assign out_entry_count = count_reg;

endmodule
